// ===== rtl/core/lcm_pkg.sv =====
// ----------------------------------------------------------------------------
// lcm_pkg - shared types and constants of the led color convert and map core
// Holds the queue entry and operation types, fixed-point constants and the
// per-led red correction table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcm_pkg;

  localparam int NUM_LEDS   = 27;
  localparam int FIFO_DEPTH = 4;
  localparam int XW         = 24;

  localparam logic [4:0]  LED_SWAP_A  = 5'd22;
  localparam logic [4:0]  LED_SWAP_B  = 5'd23;
  localparam logic [6:0]  BASE_SWAP_A = 7'd66;
  localparam logic [6:0]  BASE_SWAP_B = 7'd63;
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [15:0] FULL_SQ     = 16'd65025;
  localparam logic [7:0]  COMP_MAX    = 8'd255;
  localparam logic [6:0]  MUL_91      = 7'd91;
  localparam logic [21:0] RECIP_1445  = 22'd2972295;
  localparam logic [10:0] DIV_1445    = 11'd1445;
  localparam logic [19:0] RECIP_100   = 20'd671089;
  localparam logic [7:0]  DUTY_FULL   = 8'd255;

  typedef enum logic [1:0] {
    MODE_CHAN,
    MODE_PWM_BLUE,
    MODE_PWM_FIXED
  } lcm_mode_t;

  typedef enum logic [1:0] {
    SLOT_RED,
    SLOT_GREEN,
    SLOT_BLUE,
    SLOT_DUTY
  } lcm_slot_t;

  typedef struct packed {
    logic          hsl;
    logic          end_led;
    logic [6:0]    base;
    logic [6:0]    pct;
    logic [XW-1:0] xr;
    logic [XW-1:0] xg;
    logic [XW-1:0] xb;
  } lcm_item_t;

  typedef struct packed {
    logic      hsl;
    logic      red;
    lcm_mode_t mode;
    logic [6:0] channel;
    logic      last;
    logic [6:0] pct;
  } lcm_ctl_t;

  function automatic logic [6:0] red_gain_pct(input logic [4:0] idx);
    logic [6:0] pct;
    unique case (idx)
      5'd0:  pct = 7'd100;
      5'd1:  pct = 7'd95;
      5'd2:  pct = 7'd98;
      5'd3:  pct = 7'd97;
      5'd4:  pct = 7'd98;
      5'd5:  pct = 7'd94;
      5'd6:  pct = 7'd100;
      5'd7:  pct = 7'd94;
      5'd8:  pct = 7'd100;
      5'd9:  pct = 7'd89;
      5'd10: pct = 7'd91;
      5'd11: pct = 7'd95;
      5'd12: pct = 7'd88;
      5'd13: pct = 7'd89;
      5'd14: pct = 7'd95;
      5'd15: pct = 7'd92;
      5'd16: pct = 7'd89;
      5'd17: pct = 7'd89;
      5'd18: pct = 7'd92;
      5'd19: pct = 7'd92;
      5'd20: pct = 7'd89;
      5'd21: pct = 7'd89;
      5'd22: pct = 7'd89;
      5'd23: pct = 7'd88;
      5'd24: pct = 7'd46;
      5'd25: pct = 7'd94;
      5'd26: pct = 7'd88;
      default: pct = PCT_FULL;
    endcase
    return pct;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcm_front.sv =====
// ----------------------------------------------------------------------------
// lcm_front - request intake and hsl preparation
// Two stages: led decode and sextant split, then hsl spread and sextant
// selection. Produces one queue entry per in-range request, drops the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [4:0]        led_number,
  input  logic [7:0]        color_a,
  input  logic [7:0]        color_b,
  input  logic [7:0]        color_c,
  output logic              push_valid,
  output lcm_pkg::lcm_item_t push_item,
  input  logic              fifo_full
);
  import lcm_pkg::*;

  logic        n_ok;
  logic        n_last;
  logic [4:0]  idx;
  logic [6:0]  base_calc;
  logic [15:0] vv_lo;
  logic [15:0] vv_hi;
  logic [10:0] hue6;

  logic        f1_v_r;
  logic        f1_hsl_r;
  logic        f1_last_r;
  logic [6:0]  f1_base_r;
  logic [6:0]  f1_pct_r;
  logic [15:0] f1_vv_r;
  logic [7:0]  f1_ll_r;
  logic [2:0]  f1_sext_r;
  logic [7:0]  f1_rem_r;
  logic [7:0]  f1_a_r;
  logic [7:0]  f1_b_r;

  logic [16:0] ll510;
  logic [15:0] mm;
  logic [23:0] t;
  logic [23:0] v;
  logic [23:0] m;
  logic [23:0] mid1;
  logic [23:0] mid2;
  logic        f2_free;
  lcm_item_t   item_nxt;

  logic        f2_v_r;
  lcm_item_t   f2_item_r;

  assign n_ok   = (led_number != 5'd0) && ({2'b00, led_number} <= 7'(NUM_LEDS));
  assign n_last = ({2'b00, led_number} == 7'(NUM_LEDS));
  assign idx    = led_number - 5'd1;
  assign hue6   = {1'b0, color_a, 2'b00} + {2'b00, color_a, 1'b0};
  assign vv_lo  = 16'(color_c) * (16'(color_b) + 16'(COMP_MAX));
  assign vv_hi  = FULL_SQ - 16'(COMP_MAX - color_c) * 16'(COMP_MAX - color_b);

  always_comb begin
    priority if (led_number == LED_SWAP_A) begin
      base_calc = BASE_SWAP_A;
    end else if (led_number == LED_SWAP_B) begin
      base_calc = BASE_SWAP_B;
    end else begin
      base_calc = {2'b00, idx} + {1'b0, idx, 1'b0};
    end
  end

  assign f2_free  = !f2_v_r || !fifo_full;
  assign in_ready = !f1_v_r || f2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (in_ready) begin
      f1_v_r <= in_valid && n_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      f1_hsl_r  <= !req_type;
      f1_last_r <= n_last;
      f1_base_r <= base_calc;
      f1_pct_r  <= red_gain_pct(idx);
      f1_vv_r   <= color_c[7] ? vv_hi : vv_lo;
      f1_ll_r   <= color_c;
      f1_sext_r <= hue6[10:8];
      f1_rem_r  <= hue6[7:0];
      f1_a_r    <= color_a;
      f1_b_r    <= color_b;
    end
  end

  // sextant spread of the scaled hsl values
  assign ll510 = {f1_ll_r, 9'b0} - {8'b0, f1_ll_r, 1'b0};
  assign mm    = 16'(ll510 - {1'b0, f1_vv_r});
  assign t     = 24'(f1_vv_r - mm) * 24'(f1_rem_r);
  assign v     = {f1_vv_r, 8'b0};
  assign m     = {mm, 8'b0};
  assign mid1  = m + t;
  assign mid2  = v - t;

  always_comb begin
    item_nxt          = '0;
    item_nxt.hsl      = f1_hsl_r;
    item_nxt.end_led  = f1_last_r;
    item_nxt.base     = f1_base_r;
    item_nxt.pct      = f1_pct_r;
    if (f1_hsl_r) begin
      unique case (f1_sext_r)
        3'd0: begin
          item_nxt.xr = v;    item_nxt.xg = mid1; item_nxt.xb = m;
        end
        3'd1: begin
          item_nxt.xr = mid2; item_nxt.xg = v;    item_nxt.xb = m;
        end
        3'd2: begin
          item_nxt.xr = m;    item_nxt.xg = v;    item_nxt.xb = mid1;
        end
        3'd3: begin
          item_nxt.xr = m;    item_nxt.xg = mid2; item_nxt.xb = v;
        end
        3'd4: begin
          item_nxt.xr = mid1; item_nxt.xg = m;    item_nxt.xb = v;
        end
        default: begin
          item_nxt.xr = v;    item_nxt.xg = m;    item_nxt.xb = mid2;
        end
      endcase
    end else begin
      item_nxt.xr = {12'b0, f1_a_r, 4'b0};
      item_nxt.xg = {12'b0, f1_b_r, 4'b0};
      item_nxt.xb = {12'b0, f1_ll_r, 4'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (f2_free) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_free) begin
      f2_item_r <= item_nxt;
    end
  end

  assign push_valid = f2_v_r;
  assign push_item  = f2_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/lcm_fifo.sv =====
// ----------------------------------------------------------------------------
// lcm_fifo - short request queue between front and back
// Register-based queue of prepared requests with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  lcm_pkg::lcm_item_t push_item,
  output logic               full,
  input  logic               pop,
  output lcm_pkg::lcm_item_t head,
  output logic               empty
);
  import lcm_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  lcm_item_t       mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CW'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcm_back.sv =====
// ----------------------------------------------------------------------------
// lcm_back - result sequencer
// Walks the head request through its result slots, one per cycle while adv
// is high, and pops it as its final slot issues.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lcm_pkg::lcm_item_t head,
  input  logic               empty,
  output logic               pop,
  input  logic               adv,
  output logic               op_valid,
  output lcm_pkg::lcm_ctl_t  op_ctl,
  output logic [lcm_pkg::XW-1:0] op_x
);
  import lcm_pkg::*;

  lcm_slot_t slot_r;
  lcm_slot_t slot_nxt;
  logic      issue;

  always_comb begin
    op_ctl      = '0;
    op_ctl.hsl  = head.hsl;
    op_ctl.pct  = head.pct;
    op_ctl.mode = MODE_CHAN;
    op_x        = head.xr;
    unique case (slot_r)
      SLOT_RED: begin
        op_ctl.red     = 1'b1;
        op_ctl.channel = head.base;
        op_x           = head.xr;
      end
      SLOT_GREEN: begin
        op_ctl.channel = head.base + 7'd1;
        op_x           = head.xg;
      end
      SLOT_BLUE: begin
        op_x = head.xb;
        if (head.end_led) begin
          op_ctl.mode = MODE_PWM_BLUE;
          op_ctl.last = 1'b1;
        end else begin
          op_ctl.channel = head.base + 7'd2;
        end
      end
      SLOT_DUTY: begin
        op_ctl.mode = MODE_PWM_FIXED;
        op_ctl.last = 1'b1;
      end
      default: begin
        op_ctl.mode = MODE_CHAN;
      end
    endcase
  end

  assign op_valid = !empty;
  assign issue    = adv && !empty;
  assign pop      = issue && op_ctl.last;
  assign slot_nxt = op_ctl.last ? SLOT_RED : lcm_slot_t'(2'(slot_r) + 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_RED;
    end else if (issue) begin
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcm_scale.sv =====
// ----------------------------------------------------------------------------
// lcm_scale - level arithmetic pipeline
// Reduces a scaled hsl value to 12 bits by constant reciprocals, passes rgb
// values through, applies the red percent and forms pwm duties. Ends in the
// output register.
`default_nettype none

module lcm_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   op_valid,
  input  lcm_pkg::lcm_ctl_t      op_ctl,
  input  logic [lcm_pkg::XW-1:0] op_x,
  output logic                   adv,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_target,
  output logic [6:0]             out_channel,
  output logic [11:0]            out_level,
  output logic                   out_last
);
  import lcm_pkg::*;

  logic        s1_v_r;
  lcm_ctl_t    s1_ctl_r;
  logic [30:0] s1_y_r;
  logic [11:0] s1_raw_r;

  logic [44:0] s2_prod;
  logic        s2_v_r;
  lcm_ctl_t    s2_ctl_r;
  logic [22:0] s2_z_r;
  logic [11:0] s2_q0_r;
  logic [11:0] s2_raw_r;

  logic [22:0] s3_rem;
  logic [11:0] s3_q;
  logic        s3_v_r;
  lcm_ctl_t    s3_ctl_r;
  logic [11:0] s3_val_r;

  logic        s4_v_r;
  lcm_ctl_t    s4_ctl_r;
  logic [18:0] s4_w_r;
  logic [11:0] s4_val_r;

  logic [38:0] s5_prod;
  logic [11:0] level_nxt;

  logic        out_v_r;
  logic        out_target_r;
  logic [6:0]  out_channel_r;
  logic [11:0] out_level_r;
  logic        out_last_r;

  assign adv = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= op_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // floor(x*4095/(65025*256)) = floor(floor(x*91/256)/1445)
  assign s2_prod = 45'(s1_y_r[30:8]) * 45'(RECIP_1445);
  assign s3_rem  = s2_z_r - 23'(s2_q0_r) * 23'(DIV_1445);
  assign s3_q    = (s3_rem >= 23'(DIV_1445)) ? s2_q0_r + 12'd1 : s2_q0_r;
  assign s5_prod = 39'(s4_w_r) * 39'(RECIP_100);

  always_comb begin
    unique case (s4_ctl_r.mode)
      MODE_CHAN:      level_nxt = (s4_ctl_r.red && s4_ctl_r.hsl) ? s5_prod[37:26] : s4_val_r;
      MODE_PWM_BLUE:  level_nxt = {4'b0, DUTY_FULL - s4_val_r[11:4]};
      MODE_PWM_FIXED: level_nxt = {4'b0, DUTY_FULL};
      default:        level_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r      <= op_ctl;
      s1_y_r        <= 31'(op_x) * 31'(MUL_91);
      s1_raw_r      <= op_x[11:0];
      s2_ctl_r      <= s1_ctl_r;
      s2_z_r        <= s1_y_r[30:8];
      s2_q0_r       <= s2_prod[43:32];
      s2_raw_r      <= s1_raw_r;
      s3_ctl_r      <= s2_ctl_r;
      s3_val_r      <= s2_ctl_r.hsl ? s3_q : s2_raw_r;
      s4_ctl_r      <= s3_ctl_r;
      s4_w_r        <= 19'(s3_val_r) * 19'(s3_ctl_r.pct);
      s4_val_r      <= s3_val_r;
      out_target_r  <= (s4_ctl_r.mode != MODE_CHAN);
      out_channel_r <= s4_ctl_r.channel;
      out_level_r   <= level_nxt;
      out_last_r    <= s4_ctl_r.last;
    end
  end

  assign out_valid   = out_v_r;
  assign out_target  = out_target_r;
  assign out_channel = out_channel_r;
  assign out_level   = out_level_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/led_color_convert_and_map_core.sv =====
// ----------------------------------------------------------------------------
// led_color_convert_and_map_core - led color request converter and mapper
// Output: one beat a cycle while out_tready is high.
// Throughput: each request takes four result slots (three for the last led),
//   issued by the back sequencer, one per cycle while the pipeline advances.
// Reset: synchronous, clears all valid flags, queue count and slot counter.
// ----------------------------------------------------------------------------
`default_nettype none

module led_color_convert_and_map_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // led_number, color_a, color_b, color_c
  input  logic        in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // channel, level
  output logic        out_tuser, // target
  output logic        out_tlast
);
  import lcm_pkg::*;

  logic       push_valid;
  lcm_item_t  push_item;
  logic       fifo_full;
  logic       fifo_empty;
  lcm_item_t  head;
  logic       back_pop;
  logic       adv;
  logic       op_valid;
  lcm_ctl_t   op_ctl;
  logic [XW-1:0] op_x;
  logic [6:0] out_channel;
  logic [11:0] out_level;

  lcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser),
    .led_number (in_tdata[4:0]),
    .color_a    (in_tdata[12:5]),
    .color_b    (in_tdata[20:13]),
    .color_c    (in_tdata[28:21]),
    .push_valid (push_valid),
    .push_item  (push_item),
    .fifo_full  (fifo_full)
  );

  lcm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (back_pop),
    .head       (head),
    .empty      (fifo_empty)
  );

  lcm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (fifo_empty),
    .pop      (back_pop),
    .adv      (adv),
    .op_valid (op_valid),
    .op_ctl   (op_ctl),
    .op_x     (op_x)
  );

  lcm_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid    (op_valid),
    .op_ctl      (op_ctl),
    .op_x        (op_x),
    .adv         (adv),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_target  (out_tuser),
    .out_channel (out_channel),
    .out_level   (out_level),
    .out_last    (out_tlast)
  );

  assign out_tdata = {5'b0, out_level, out_channel};

  a_pop_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    back_pop |-> op_ctl.last)
    else $error("request popped before its final slot");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    back_pop |-> !fifo_empty)
    else $error("pop from empty queue");

  a_pwm_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == out_tlast))
    else $error("pwm beat and final beat disagree");

endmodule

`default_nettype wire

// ===== dv/tb_led_color_convert_and_map_core.sv =====
// ----------------------------------------------------------------------------
// tb_led_color_convert_and_map_core - color request converter testbench
// Sends HSL and RGB color requests for in-range and out-of-range led numbers,
// checks each result beat against a predictor of the HSL conversion, the red
// correction and channel map, or typed-row levels; both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_color_convert_and_map_core;

  localparam logic REQ_HSL  = 1'b0;
  localparam logic REQ_RGB  = 1'b1;
  localparam logic TGT_CHAN = 1'b0;
  localparam logic TGT_PWM  = 1'b1;

  localparam int N_LEDS     = 27;
  localparam int N_RANDOM   = 346;
  localparam int MAX_GAP    = 12;
  localparam int DRAIN_WAIT = 20;
  localparam int LIMIT      = 200000;

  localparam logic [6:0] RED_PCT [N_LEDS] = '{
    7'd100, 7'd95, 7'd98, 7'd97, 7'd98, 7'd94, 7'd100, 7'd94, 7'd100, 7'd89,
    7'd91, 7'd95, 7'd88, 7'd89, 7'd95, 7'd92, 7'd89, 7'd89, 7'd92, 7'd92,
    7'd89, 7'd89, 7'd89, 7'd88, 7'd46, 7'd94, 7'd88
  };

  typedef struct packed {
    logic        target;
    logic [6:0]  channel;
    logic [11:0] level;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic        req;
    logic [4:0]  led;
    logic [7:0]  ca;
    logic [7:0]  cb;
    logic [7:0]  cc;
    logic        typed;
    logic [2:0]  nbeat;
    logic [11:0] lv0;
    logic [11:0] lv1;
    logic [11:0] lv2;
    logic [11:0] lv3;
  } req_row_t;

  localparam int N_DIR = 24;

  // typed rows carry beat count and levels; the rest go through the predictor
  localparam req_row_t DIR_ROWS [N_DIR] = '{
    '{REQ_RGB, 5'd1,  8'd255, 8'd255, 8'd255, 1'b1, 3'd4, 12'd4080, 12'd4080, 12'd4080, 12'd255},
    '{REQ_RGB, 5'd1,  8'd0,   8'd0,   8'd0,   1'b1, 3'd4, 12'd0,    12'd0,    12'd0,    12'd255},
    '{REQ_RGB, 5'd27, 8'd255, 8'd255, 8'd255, 1'b1, 3'd3, 12'd4080, 12'd4080, 12'd0,    12'd0},
    '{REQ_RGB, 5'd27, 8'd0,   8'd0,   8'd0,   1'b1, 3'd3, 12'd0,    12'd0,    12'd255,  12'd0},
    '{REQ_RGB, 5'd0,  8'd255, 8'd1,   8'd128, 1'b1, 3'd0, 12'd0,    12'd0,    12'd0,    12'd0},
    '{REQ_RGB, 5'd28, 8'd12,  8'd34,  8'd56,  1'b1, 3'd0, 12'd0,    12'd0,    12'd0,    12'd0},
    '{REQ_HSL, 5'd31, 8'd255, 8'd255, 8'd255, 1'b1, 3'd0, 12'd0,    12'd0,    12'd0,    12'd0},
    '{REQ_HSL, 5'd5,  8'd200, 8'd255, 8'd0,   1'b1, 3'd4, 12'd0,    12'd0,    12'd0,    12'd255},
    '{REQ_HSL, 5'd1,  8'd77,  8'd0,   8'd255, 1'b1, 3'd4, 12'd4095, 12'd4095, 12'd4095, 12'd255},
    '{REQ_HSL, 5'd1,  8'd255, 8'd255, 8'd255, 1'b1, 3'd4, 12'd4095, 12'd4095, 12'd4095, 12'd255},
    '{REQ_HSL, 5'd2,  8'd0,   8'd255, 8'd128, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd7,  8'd43,  8'd255, 8'd128, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd9,  8'd86,  8'd255, 8'd128, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd13, 8'd128, 8'd255, 8'd128, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd16, 8'd171, 8'd255, 8'd128, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd20, 8'd213, 8'd255, 8'd128, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd25, 8'd255, 8'd200, 8'd60,  1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd22, 8'd30,  8'd180, 8'd100, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd23, 8'd140, 8'd90,  8'd200, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd27, 8'd180, 8'd255, 8'd127, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_RGB, 5'd22, 8'h12,  8'h34,  8'h56,  1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_RGB, 5'd23, 8'hab,  8'hcd,  8'hef,  1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd3,  8'd10,  8'd0,   8'd100, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{REQ_HSL, 5'd26, 8'd0,   8'd1,   8'd128, 1'b0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  beat_t pending_beats[$];
  int    fail_count = 0;
  int    beat_count = 0;
  int    hsl_reqs = 0;
  int    rgb_reqs = 0;
  int    dropped_reqs = 0;
  int    cycle_count = 0;
  int    hold_left = 0;
  bit    quiet = 1'b0;

  led_color_convert_and_map_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // six-sextant hsl, all terms scaled by 65025*256, floored to 12 bits
  function automatic void hsl_to_levels(input logic [7:0] hue, input logic [7:0] sat,
                                        input logic [7:0] lum, output logic [11:0] red,
                                        output logic [11:0] grn, output logic [11:0] blu);
    longint unsigned scale, hi, lo, hi_s, lo_s, ramp, rise, fall, xr, xg, xb;
    int unsigned     sector, frac;
    scale = 64'd65025 * 64'd256;
    if (lum <= 8'd127)
      hi = longint'(lum) * (255 + longint'(sat));
    else
      hi = 255 * longint'(lum) + 255 * longint'(sat) - longint'(lum) * longint'(sat);
    xr = longint'(lum) * 255 * 256;
    xg = xr;
    xb = xr;
    if (hi > 0) begin
      lo     = 510 * longint'(lum) - hi;
      sector = (6 * int'(hue)) >> 8;
      frac   = (6 * int'(hue)) & 8'hff;
      hi_s   = hi * 256;
      lo_s   = lo * 256;
      ramp   = (hi - lo) * frac;
      rise   = lo_s + ramp;
      fall   = hi_s - ramp;
      case (sector)
        0:       begin xr = hi_s; xg = rise; xb = lo_s; end
        1:       begin xr = fall; xg = hi_s; xb = lo_s; end
        2:       begin xr = lo_s; xg = hi_s; xb = rise; end
        3:       begin xr = lo_s; xg = fall; xb = hi_s; end
        4:       begin xr = rise; xg = lo_s; xb = hi_s; end
        default: begin xr = hi_s; xg = lo_s; xb = fall; end
      endcase
    end
    red = 12'(xr * 4095 / scale);
    grn = 12'(xg * 4095 / scale);
    blu = 12'(xb * 4095 / scale);
  endfunction

  function automatic int map_request(input logic req, input logic [4:0] led,
                                     input logic [7:0] ca, input logic [7:0] cb,
                                     input logic [7:0] cc, output beat_t bt [4]);
    logic [11:0] red, grn, blu;
    logic [6:0]  base;
    int unsigned pct;
    bt = '{default: '0};
    if (led < 1 || led > N_LEDS)
      return 0;
    if (req == REQ_HSL) begin
      hsl_to_levels(ca, cb, cc, red, grn, blu);
      pct = RED_PCT[led - 1];
      red = 12'((int'(red) * pct) / 100);
    end else begin
      red = {ca, 4'h0};
      grn = {cb, 4'h0};
      blu = {cc, 4'h0};
    end
    if (led == 5'd22)
      base = 7'd66;
    else if (led == 5'd23)
      base = 7'd63;
    else
      base = 7'(3 * (int'(led) - 1));
    bt[0] = '{TGT_CHAN, base, red, 1'b0};
    bt[1] = '{TGT_CHAN, base + 7'd1, grn, 1'b0};
    if (led == N_LEDS) begin
      bt[2] = '{TGT_PWM, 7'd0, 12'(8'd255 - blu[11:4]), 1'b1};
      return 3;
    end
    bt[2] = '{TGT_CHAN, base + 7'd2, blu, 1'b0};
    bt[3] = '{TGT_PWM, 7'd0, 12'd255, 1'b1};
    return 4;
  endfunction

  task automatic send_request(input logic req, input logic [4:0] led, input logic [7:0] ca,
                              input logic [7:0] cb, input logic [7:0] cc,
                              input logic typed, input int nbeat,
                              input logic [11:0] lv [4]);
    beat_t bt [4];
    int    gap, cnt;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, cc, cb, ca, led};
    do @(posedge clk); while (!in_tready);
    cnt = map_request(req, led, ca, cb, cc, bt);
    if (typed) begin
      cnt = nbeat;
      for (int k = 0; k < 4; k++) bt[k].level = lv[k];
    end
    for (int k = 0; k < cnt; k++) pending_beats.push_back(bt[k]);
    if (cnt == 0) dropped_reqs++;
    else if (req == REQ_HSL) hsl_reqs++;
    else rgb_reqs++;
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  // result side: per-beat stall, compare against oldest expectation
  always @(posedge clk) begin
    beat_t got, want;
    int    hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 1;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[6:0], out_tdata[18:7], out_tlast};
        beat_count++;
        if (pending_beats.size() == 0) begin
          $error("unexpected result beat: target %0d channel %0d level %0d last %0d",
                 got.target, got.channel, got.level, got.last);
          fail_count++;
        end else begin
          want = pending_beats.pop_front();
          if (got.target !== want.target) begin
            $error("target mismatch: expected %0d got %0d", want.target, got.target);
            fail_count++;
          end
          if (got.channel !== want.channel) begin
            $error("channel mismatch: expected %0d got %0d", want.channel, got.channel);
            fail_count++;
          end
          if (got.level !== want.level) begin
            $error("level mismatch: expected %0d got %0d", want.level, got.level);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last mismatch: expected %0d got %0d", want.last, got.last);
            fail_count++;
          end
        end
        hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
        out_tready <= (hold == 0);
        hold_left  <= hold;
      end else if (!out_tready) begin
        if (hold_left <= 1) out_tready <= 1'b1;
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    req_row_t    row;
    logic [11:0] lv [4];
    logic        req;
    logic [4:0]  led;
    logic [7:0]  ca, cb, cc;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      lv  = '{row.lv0, row.lv1, row.lv2, row.lv3};
      send_request(row.req, row.led, row.ca, row.cb, row.cc, row.typed, int'(row.nbeat), lv);
    end
    wait_drained();

    lv = '{default: '0};
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = ((i / 40) % 4) == 2;
      req   = 1'($urandom_range(0, 1));
      led   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, N_LEDS));
      ca    = 8'($urandom);
      cb    = 8'($urandom);
      cc    = 8'($urandom);
      case ($urandom_range(0, 9))
        0:       cb = 8'd0;
        1:       cc = 8'd0;
        2:       cc = 8'd255;
        3:       cb = 8'd255;
        default: ;
      endcase
      send_request(req, led, ca, cb, cc, 1'b0, 0, lv);
      if (i == 150) wait_drained();
    end
    quiet = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("requests: %0d hsl, %0d rgb, %0d out of range led; %0d result beats checked",
             hsl_reqs, rgb_reqs, dropped_reqs, beat_count);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lcm_pkg.sv
rtl/core/lcm_front.sv
rtl/core/lcm_fifo.sv
rtl/core/lcm_back.sv
rtl/core/lcm_scale.sv
rtl/core/led_color_convert_and_map_core.sv
dv/tb_led_color_convert_and_map_core.sv
